>>> src/dafmt_pkg.sv
`default_nettype none

package dafmt_pkg;

    localparam int VALUE_W       = 32;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
    localparam int SHIFT_W       = BCD_W + VALUE_W;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);
    localparam int IDX_W         = $clog2(NUM_DIGITS);
    localparam int CHAR_W        = 6;
    localparam int OUT_DATA_W    = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(STEPS - 1);
    localparam logic [IDX_W-1:0]  LAST_DIGIT  = IDX_W'(NUM_DIGITS - 1);
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    // One double-dabble bit: correct every BCD digit of five or more, then shift.
    function automatic logic [SHIFT_W-1:0] dabble_bit(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] t;
        logic [DIGIT_W-1:0] d;
        t = s;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = t[VALUE_W + i*DIGIT_W +: DIGIT_W];
            if (d >= DABBLE_MIN) begin
                t[VALUE_W + i*DIGIT_W +: DIGIT_W] = d + DABBLE_ADD;
            end
        end
        return t << 1;
    endfunction

    function automatic logic [SHIFT_W-1:0] dabble_step(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] t;
        t = s;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            t = dabble_bit(t);
        end
        return t;
    endfunction

    // Digit 0 is the most significant one.
    function automatic logic [DIGIT_W-1:0] get_digit(input logic [BCD_W-1:0] bcd,
                                                    input logic [IDX_W-1:0] idx);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (idx == IDX_W'(i)) begin
                d = bcd[(NUM_DIGITS-1-i)*DIGIT_W +: DIGIT_W];
            end
        end
        return d;
    endfunction

    // Index of the first nonzero digit; a zero value starts at the last digit.
    function automatic logic [IDX_W-1:0] first_digit(input logic [BCD_W-1:0] bcd);
        logic [IDX_W-1:0] idx;
        idx = LAST_DIGIT;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            if (bcd[(NUM_DIGITS-1-i)*DIGIT_W +: DIGIT_W] != '0) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> src/dafmt_conv.sv
`default_nettype none

module dafmt_conv
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dafmt_pkg::VALUE_W-1:0] in_value,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output logic [dafmt_pkg::BCD_W-1:0]        push_bcd
);
    import dafmt_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [SHIFT_W-1:0]  stepped;
    logic                at_end;
    logic                hold;

    assign stepped    = dabble_step(shift_reg);
    assign at_end     = busy_reg && (step_reg == LAST_STEP);
    assign push_valid = at_end;
    assign push_bcd   = stepped[SHIFT_W-1 -: BCD_W];
    // Stall on the final step while the queue is full.
    assign hold       = at_end && !push_ready;
    assign in_ready   = !busy_reg || (at_end && push_ready);

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        if (busy_reg && !hold) begin
            shift_next = stepped;
            step_next  = step_reg + 1'b1;
            if (at_end) begin
                busy_next = 1'b0;
            end
        end
        if (in_valid && in_ready) begin
            busy_next  = 1'b1;
            step_next  = '0;
            shift_next = {{BCD_W{1'b0}}, in_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

`default_nettype wire

>>> src/dafmt_queue.sv
`default_nettype none

module dafmt_queue
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push_valid,
    output logic                             push_ready,
    input  wire logic [dafmt_pkg::BCD_W-1:0] push_bcd,
    output logic                             pop_valid,
    input  wire logic                        pop_ready,
    output logic [dafmt_pkg::BCD_W-1:0]      pop_bcd
);
    import dafmt_pkg::*;

    logic [BCD_W-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_bcd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_bcd;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a push");

endmodule

`default_nettype wire

>>> src/dafmt_emit.sv
`default_nettype none

module dafmt_emit
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pop_valid,
    output logic                             pop_ready,
    input  wire logic [dafmt_pkg::BCD_W-1:0] pop_bcd,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [dafmt_pkg::CHAR_W-1:0]     out_char,
    output logic                             out_last
);
    import dafmt_pkg::*;

    logic               active_reg, active_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic               advance;
    logic               at_last;

    assign advance   = !out_valid_reg || out_ready;
    assign at_last   = (idx_reg == LAST_DIGIT);
    // A new number is taken as soon as the current one hands over its final digit.
    assign pop_ready = !active_reg || (advance && at_last);

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        active_next    = active_reg;
        bcd_next       = bcd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            out_valid_next = active_reg;
            out_char_next  = ASCII_ZERO + CHAR_W'(get_digit(bcd_reg, idx_reg));
            out_last_next  = at_last;
            if (active_reg) begin
                idx_next = idx_reg + 1'b1;
                if (at_last) begin
                    active_next = 1'b0;
                end
            end
        end
        if (pop_valid && pop_ready) begin
            active_next = 1'b1;
            bcd_next    = pop_bcd;
            idx_next    = first_digit(pop_bcd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg <= LAST_DIGIT))
        else $error("digit index out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && advance && at_last && !pop_valid) |=> !active_reg)
        else $error("number still active after its final digit");

endmodule

`default_nettype wire

>>> src/decimal_ascii_formatter_unit.sv
// Binary to decimal ASCII formatter.
// The slave stream takes one 32-bit unsigned value per request. The master
// stream returns its decimal digits as ASCII characters, most significant
// first, with leading zeros dropped; zero gives the single character '0'.
// m_tlast marks the final character of each value.
// A double-dabble unit converts four bits per cycle unless the queue is full
// when it reaches its final step; a converted value passes through the queue
// to the emitter, whose output register presents each character.
// The converter takes a new value only as it hands over the previous one, and
// the character emitter sends one character per cycle while the receiver is
// ready.
// A two-entry queue holds converted values between the converter and the
// emitter; when the receiver stalls, the output register holds its
// character, the queue fills, and s_tready drops once the converter has
// finished a value it cannot hand over.
// Reset clears the converter, the queue and the output register; no
// request is in flight after reset.
`default_nettype none

module decimal_ascii_formatter_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dafmt_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [dafmt_pkg::OUT_DATA_W-1:0]      m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                                  m_tlast
);
    import dafmt_pkg::*;

    logic              push_valid, push_ready;
    logic [BCD_W-1:0]  push_bcd;
    logic              pop_valid, pop_ready;
    logic [BCD_W-1:0]  pop_bcd;
    logic [CHAR_W-1:0] out_char;

    dafmt_conv u_conv
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_bcd   (push_bcd)
    );

    dafmt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_bcd   (push_bcd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_bcd    (pop_bcd)
    );

    dafmt_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_bcd   (pop_bcd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - CHAR_W){1'b0}}, out_char};

endmodule

`default_nettype wire
